// ===== design/ptw_pkg.sv =====
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared constants, codes and types of the four-level page table walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

	localparam int STORE_PAGES = 64;
	localparam int TABLE_ENTRIES = 512;
	localparam int STORE_WORDS = STORE_PAGES * TABLE_ENTRIES;
	localparam int ADDR_W = $clog2(STORE_WORDS);
	localparam int DATA_W = 64;
	localparam int ROOT_W = 6;
	localparam int IDX_W = 15;
	localparam int VA_W = 48;
	localparam int PA_W = 52;
	localparam int FRAME_W = 40;

	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_READ = 2'd1;
	localparam logic [1:0] REQ_XLATE = 2'd2;

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_NOT_MAPPED = 2'd1;
	localparam logic [1:0] STATUS_OUTSIDE = 2'd2;

	localparam logic [1:0] SIZE_4K = 2'd0;
	localparam logic [1:0] SIZE_2M = 2'd1;
	localparam logic [1:0] SIZE_1G = 2'd2;

	localparam int PRESENT_BIT = 0;
	localparam int PS_BIT = 7;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_WALK
	} state_t;

	typedef enum logic [1:0] {
		LVL_PML4,
		LVL_PDPT,
		LVL_PD,
		LVL_PT
	} level_t;

	function automatic logic [8:0] level_index(input logic [VA_W-1:0] va, input level_t lvl);
		logic [8:0] idx;
		unique case (lvl)
			LVL_PML4: idx = va[47:39];
			LVL_PDPT: idx = va[38:30];
			LVL_PD:   idx = va[29:21];
			LVL_PT:   idx = va[20:12];
			default:  idx = va[47:39];
		endcase
		return idx;
	endfunction

	function automatic level_t level_next(input level_t lvl);
		level_t nxt;
		unique case (lvl)
			LVL_PML4: nxt = LVL_PDPT;
			LVL_PDPT: nxt = LVL_PD;
			LVL_PD:   nxt = LVL_PT;
			LVL_PT:   nxt = LVL_PT;
			default:  nxt = LVL_PT;
		endcase
		return nxt;
	endfunction

endpackage

// ===== design/ptw_ram.sv =====
// ----------------------------------------------------------------------------
// ptw_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module ptw_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/four_level_page_table_walker.sv =====
// ----------------------------------------------------------------------------
// four_level_page_table_walker
// Page table store with entry write/read and four-level address translation.
// ----------------------------------------------------------------------------
// After reset the block zeroes its table store, one entry per cycle, keeping
// busy high until all 32768 entries are clear. A transaction is taken when
// start is high and busy is low. A write, an out-of-range access or an unused
// request needs no store read, an entry read needs one, and a translation one
// per table level, since every level is a dependent read of the single store
// port. The result is registered, with done high for exactly one cycle; the
// receiver cannot stall it, and a new transaction may be taken in that same
// cycle. The user must write root_table_page through cfg_we and cfg_data only
// while the block is idle; the block itself does not enforce this.
module four_level_page_table_walker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ptw_pkg::ROOT_W-1:0]    cfg_data,
	input  logic                          start,
	input  logic [1:0]                    req_type,
	input  logic [ptw_pkg::IDX_W-1:0]     entry_index,
	input  logic [ptw_pkg::DATA_W-1:0]    entry_data,
	input  logic [ptw_pkg::VA_W-1:0]      virt_addr,
	output logic                          busy,
	output logic                          done,
	output logic [1:0]                    status,
	output logic [ptw_pkg::PA_W-1:0]      phys_addr,
	output logic [1:0]                    map_size,
	output logic [ptw_pkg::DATA_W-1:0]    read_data
);

	import ptw_pkg::*;

	state_t state_q, state_d;
	level_t level_q, level_d;
	logic [VA_W-1:0] va_q;
	logic [ADDR_W-1:0] clr_q;
	logic [ROOT_W-1:0] root_q;

	logic ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [DATA_W-1:0] ram_wdata;
	logic [DATA_W-1:0] ram_rdata;

	logic accept;
	logic idx_ok;
	logic root_ok;
	logic present;
	logic leaf_ps;
	logic [FRAME_W-1:0] next_pg;
	logic ptr_ok;
	logic walk_end;
	logic clear_last;

	logic res_valid_d;
	logic [1:0] status_d;
	logic [PA_W-1:0] pa_d;
	logic [1:0] size_d;
	logic [DATA_W-1:0] rdata_d;

	logic done_q;
	logic [1:0] status_q;
	logic [PA_W-1:0] pa_q;
	logic [1:0] size_q;
	logic [DATA_W-1:0] rd_q;

	ptw_ram #(
		.WIDTH(DATA_W),
		.DEPTH(STORE_WORDS)
	) u_store (
		.clk(clk),
		.we(ram_we),
		.addr(ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	assign busy = (state_q != ST_IDLE);
	assign accept = start && (state_q == ST_IDLE);
	assign idx_ok = 32'(entry_index) < STORE_WORDS;
	assign root_ok = 32'(root_q) < STORE_PAGES;
	assign clear_last = (clr_q == ADDR_W'(STORE_WORDS - 1));

	assign present = ram_rdata[PRESENT_BIT];
	assign leaf_ps = ram_rdata[PS_BIT] && ((level_q == LVL_PDPT) || (level_q == LVL_PD));
	assign next_pg = ram_rdata[51:12];
	assign ptr_ok = next_pg < FRAME_W'(STORE_PAGES);
	assign walk_end = !present || leaf_ps || (level_q == LVL_PT) || !ptr_ok;

	always_comb begin
		state_d = state_q;
		level_d = level_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				level_d = LVL_PML4;
				if (accept) begin
					if (req_type == REQ_READ && idx_ok) begin
						state_d = ST_READ;
					end else if (req_type == REQ_XLATE && root_ok) begin
						state_d = ST_WALK;
					end
				end
			end
			ST_READ: begin
				state_d = ST_IDLE;
			end
			ST_WALK: begin
				if (walk_end) begin
					state_d = ST_IDLE;
				end else begin
					level_d = level_next(level_q);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ram_we = 1'b0;
		ram_addr = ADDR_W'(entry_index);
		ram_wdata = entry_data;
		res_valid_d = 1'b0;
		status_d = STATUS_OK;
		pa_d = '0;
		size_d = SIZE_4K;
		rdata_d = '0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				ram_addr = clr_q;
				ram_wdata = '0;
			end
			ST_IDLE: begin
				if (req_type == REQ_XLATE) begin
					ram_addr = ADDR_W'({root_q, level_index(virt_addr, LVL_PML4)});
				end
				if (accept) begin
					unique case (req_type)
						REQ_WRITE: begin
							ram_we = idx_ok;
							res_valid_d = 1'b1;
							status_d = idx_ok ? STATUS_OK : STATUS_OUTSIDE;
						end
						REQ_READ: begin
							res_valid_d = !idx_ok;
							status_d = STATUS_OUTSIDE;
						end
						REQ_XLATE: begin
							res_valid_d = !root_ok;
							status_d = STATUS_OUTSIDE;
						end
						default: begin
							res_valid_d = 1'b1;
						end
					endcase
				end
			end
			ST_READ: begin
				res_valid_d = 1'b1;
				rdata_d = ram_rdata;
			end
			ST_WALK: begin
				ram_addr = ADDR_W'({next_pg, level_index(va_q, level_next(level_q))});
				res_valid_d = walk_end;
				if (!present) begin
					status_d = STATUS_NOT_MAPPED;
				end else if (leaf_ps && level_q == LVL_PDPT) begin
					pa_d = {ram_rdata[51:30], va_q[29:0]};
					size_d = SIZE_1G;
				end else if (leaf_ps) begin
					pa_d = {ram_rdata[51:21], va_q[20:0]};
					size_d = SIZE_2M;
				end else if (level_q == LVL_PT) begin
					pa_d = {ram_rdata[51:12], va_q[11:0]};
				end else begin
					status_d = STATUS_OUTSIDE;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			level_q <= LVL_PML4;
			clr_q <= '0;
			root_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			level_q <= level_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg_we) begin
				root_q <= cfg_data;
			end
			done_q <= res_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			va_q <= virt_addr;
		end
		if (res_valid_d) begin
			status_q <= status_d;
			pa_q <= pa_d;
			size_q <= size_d;
			rd_q <= rdata_d;
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign phys_addr = pa_q;
	assign map_size = size_q;
	assign read_data = rd_q;

endmodule
